// File: design/grid_cell_connectivity_defines.svh
// ----------------------------------------------------------------------------
// grid_cell_connectivity assertion macros
// Concurrent assertion helpers used by the grid cell connectivity block.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_CONNECTIVITY_DEFINES_SVH
`define GRID_CELL_CONNECTIVITY_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define GCC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define GCC_ASSERT(label, prop, msg) \
  `GCC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: design/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Types, constants and corner tables for the grid cell connectivity block.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int unsigned MAX_DIVISIONS = 255;
  localparam int unsigned NODE_W        = 24;
  localparam int unsigned LAYER_W       = 17;
  localparam int unsigned ROW_W         = 9;

  typedef enum logic [1:0] {
    SHAPE_TET   = 2'd0,
    SHAPE_PRISM = 2'd1,
    SHAPE_HEX   = 2'd2
  } shape_e;

  typedef enum logic [2:0] {
    CFG_CELLS_X  = 3'd0,
    CFG_CELLS_Y  = 3'd1,
    CFG_CELLS_Z  = 3'd2,
    CFG_MESH     = 3'd3,
    CFG_MATERIAL = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] KIND_TET   = 2'd0;
  localparam logic [1:0] KIND_PRISM = 2'd1;

  localparam logic [2:0] LAST_TET   = 3'd4;
  localparam logic [2:0] LAST_PRISM = 3'd1;
  localparam logic [2:0] LAST_ONE   = 3'd0;

  // corner code: [1:0] bottom-face position, [2] top face
  localparam logic [2:0] TET_CODES [5][4] = '{
    '{3'd0, 3'd1, 3'd3, 3'd4},
    '{3'd5, 3'd4, 3'd6, 3'd1},
    '{3'd2, 3'd3, 3'd1, 3'd6},
    '{3'd7, 3'd6, 3'd4, 3'd3},
    '{3'd4, 3'd1, 3'd3, 3'd6}
  };

  localparam logic [2:0] PRISM_CORNERS [2][6] = '{
    '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6},
    '{3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7}
  };

  localparam logic [LAYER_W-1:0] LAYER_RST = LAYER_W'(4);

  typedef struct packed {
    logic [7:0]         nx;
    logic [7:0]         ny;
    logic [7:0]         nz;
    logic [ROW_W-1:0]   row;
    logic [LAYER_W-1:0] layer;
    logic [1:0]         kind;
    logic [15:0]        material;
  } geom_t;

  typedef struct packed {
    logic              bad;
    shape_e            shape;
    logic              parity;
    logic [2:0]        last_idx;
    logic [NODE_W-1:0] first;
  } cell_t;

  typedef struct packed {
    logic [7:0][NODE_W-1:0] nodes;
    shape_e                 shape;
    logic [15:0]            material;
    logic                   bad;
    logic                   last;
  } elem_t;

  function automatic logic [7:0] clamp_div(input logic [7:0] v);
    logic [7:0] r;
    r = (32'(v) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : v;
    return r;
  endfunction

  function automatic logic [LAYER_W-1:0] calc_layer(input logic [7:0] nx,
                                                     input logic [7:0] ny);
    logic [2*ROW_W-1:0] p;
    p = ({1'b0, nx} + ROW_W'(1)) * ({1'b0, ny} + ROW_W'(1));
    return p[LAYER_W-1:0];
  endfunction

endpackage

// File: design/grid_cell_connectivity.sv
// ----------------------------------------------------------------------------
// grid_cell_connectivity
// Volume element node lists for one cell of a structured box grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one cell index triple per
// item. Output channel (out_valid_o / out_stall_i) gives one volume element
// per item: five tetrahedra, two prisms or one hexahedron per cell, with
// last_element_o on the final one. A cell outside the grid gives a single
// item with cell_bad_o set and all node numbers zero.
// Registers are written through cfg_valid_i / cfg_ready_o at cfg_index_i;
// cfg_ready_o is always high. Write them only while the block is idle.
// The first element of a cell passes the input register, the cell register
// and the result register, in that order, after the cell is accepted.
// Throughput: one element per cycle while out_stall_i is low, set by the
// element sequencer driving the single result register.
// Reset clears all valid flags and loads the register defaults (1x1x1
// grid, hexahedral, material 0). While out_stall_i is high the result
// holds and the pipeline fills; in_stall_o rises once every stage is full.
// ----------------------------------------------------------------------------
`include "grid_cell_connectivity_defines.svh"

module grid_cell_connectivity
  import gcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_y_i,
  input  logic [7:0]  cell_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] node_a_o,
  output logic [23:0] node_b_o,
  output logic [23:0] node_c_o,
  output logic [23:0] node_d_o,
  output logic [23:0] node_e_o,
  output logic [23:0] node_f_o,
  output logic [23:0] node_g_o,
  output logic [23:0] node_h_o,
  output logic [1:0]  element_shape_o,
  output logic [15:0] element_material_o,
  output logic        cell_bad_o,
  output logic        last_element_o
);

  geom_t geom;
  cell_t cell_info;
  logic  cell_valid;
  logic  cell_done;
  elem_t elem;

  gcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  gcc_corner u_corner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .geom_i       (geom),
    .cell_done_i  (cell_done),
    .cell_valid_o (cell_valid),
    .cell_o       (cell_info)
  );

  gcc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid),
    .cell_i       (cell_info),
    .geom_i       (geom),
    .cell_done_o  (cell_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .elem_o       (elem)
  );

  assign node_a_o           = elem.nodes[0];
  assign node_b_o           = elem.nodes[1];
  assign node_c_o           = elem.nodes[2];
  assign node_d_o           = elem.nodes[3];
  assign node_e_o           = elem.nodes[4];
  assign node_f_o           = elem.nodes[5];
  assign node_g_o           = elem.nodes[6];
  assign node_h_o           = elem.nodes[7];
  assign element_shape_o    = elem.shape;
  assign element_material_o = elem.material;
  assign cell_bad_o         = elem.bad;
  assign last_element_o     = elem.last;

  `GCC_ASSERT(a_bad_single, (out_valid_o && cell_bad_o) |-> (last_element_o && (node_a_o == 24'd0)), "bad cell item not single")
  `GCC_ASSERT(a_hex_single, (out_valid_o && (element_shape_o == SHAPE_HEX)) |-> last_element_o, "hexahedron not last")
  `GCC_ASSERT(a_done_valid, cell_done |-> cell_valid, "cell retired while empty")
  `GCC_ASSERT(a_tet_tail, (out_valid_o && (element_shape_o == SHAPE_TET) && !cell_bad_o) |-> ((node_e_o == 24'd0) && (node_h_o == 24'd0)), "tetrahedron tail nonzero")

endmodule

// File: design/gcc_cfg.sv
// ----------------------------------------------------------------------------
// gcc_cfg
// Configuration registers and the derived node layer stride.
// ----------------------------------------------------------------------------
module gcc_cfg
  import gcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output geom_t       geom_o
);

  logic [7:0]         nx_q, nx_d;
  logic [7:0]         ny_q, ny_d;
  logic [7:0]         nz_q, nz_d;
  logic [1:0]         kind_q, kind_d;
  logic [15:0]        mat_q, mat_d;
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    nx_d    = nx_q;
    ny_d    = ny_q;
    nz_d    = nz_q;
    kind_d  = kind_q;
    mat_d   = mat_q;
    layer_d = layer_q;
    if (wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CELLS_X: begin
          nx_d    = clamp_div(cfg_data_i[7:0]);
          layer_d = calc_layer(nx_d, ny_q);
        end
        CFG_CELLS_Y: begin
          ny_d    = clamp_div(cfg_data_i[7:0]);
          layer_d = calc_layer(nx_q, ny_d);
        end
        CFG_CELLS_Z:  nz_d   = clamp_div(cfg_data_i[7:0]);
        CFG_MESH:     kind_d = cfg_data_i[1:0];
        CFG_MATERIAL: mat_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q    <= 8'd1;
      ny_q    <= 8'd1;
      nz_q    <= 8'd1;
      kind_q  <= 2'd2;
      mat_q   <= 16'd0;
      layer_q <= LAYER_RST;
    end else begin
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      nz_q    <= nz_d;
      kind_q  <= kind_d;
      mat_q   <= mat_d;
      layer_q <= layer_d;
    end
  end

  assign geom_o.nx       = nx_q;
  assign geom_o.ny       = ny_q;
  assign geom_o.nz       = nz_q;
  assign geom_o.row      = {1'b0, nx_q} + ROW_W'(1);
  assign geom_o.layer    = layer_q;
  assign geom_o.kind     = kind_q;
  assign geom_o.material = mat_q;

endmodule

// File: design/gcc_corner.sv
// ----------------------------------------------------------------------------
// gcc_corner
// Input register, range check and base node number of the cell.
// ----------------------------------------------------------------------------
module gcc_corner
  import gcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] cell_x_i,
  input  logic [7:0] cell_y_i,
  input  logic [7:0] cell_z_i,
  input  geom_t      geom_i,
  input  logic       cell_done_i,
  output logic       cell_valid_o,
  output cell_t      cell_o
);

  logic                 in_valid_q;
  logic [7:0]           cx_q, cy_q, cz_q;
  logic                 crn_valid_q;
  cell_t                cell_q, cell_d;
  logic                 crn_free;
  logic                 in_free;
  logic [NODE_W:0]      zprod;
  logic [LAYER_W-1:0]   yprod;

  assign crn_free   = !crn_valid_q || cell_done_i;
  assign in_free    = !in_valid_q || crn_free;
  assign in_stall_o = !in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
      cz_q <= cell_z_i;
    end
  end

  assign zprod = {17'd0, cz_q} * {8'd0, geom_i.layer};
  assign yprod = {9'd0, cy_q} * {8'd0, geom_i.row};

  always_comb begin
    cell_d.bad    = (cx_q >= geom_i.nx) || (cy_q >= geom_i.ny) || (cz_q >= geom_i.nz);
    cell_d.parity = cx_q[0] ^ cy_q[0] ^ cz_q[0];
    cell_d.first  = zprod[NODE_W-1:0] + {7'd0, yprod} + {16'd0, cx_q};
    unique case (geom_i.kind)
      KIND_TET:   cell_d.shape = SHAPE_TET;
      KIND_PRISM: cell_d.shape = SHAPE_PRISM;
      default:    cell_d.shape = SHAPE_HEX;
    endcase
    if (cell_d.bad) begin
      cell_d.last_idx = LAST_ONE;
    end else begin
      case (cell_d.shape)
        SHAPE_TET:   cell_d.last_idx = LAST_TET;
        SHAPE_PRISM: cell_d.last_idx = LAST_PRISM;
        default:     cell_d.last_idx = LAST_ONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crn_valid_q <= 1'b0;
    end else if (crn_free) begin
      crn_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (crn_free && in_valid_q) begin
      cell_q <= cell_d;
    end
  end

  assign cell_valid_o = crn_valid_q;
  assign cell_o       = cell_q;

endmodule

// File: design/gcc_emit.sv
// ----------------------------------------------------------------------------
// gcc_emit
// Element sequencer: corner nodes, element node lists and result register.
// ----------------------------------------------------------------------------
module gcc_emit
  import gcc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cell_valid_i,
  input  cell_t cell_i,
  input  geom_t geom_i,
  output logic  cell_done_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output elem_t elem_o
);

  logic                   out_valid_q;
  elem_t                  elem_q, elem_d;
  logic [2:0]             idx_q, idx_d;
  logic                   out_free;
  logic                   issue;
  logic                   last;
  logic [NODE_W-1:0]      corner [8];
  logic [1:0]             pos;
  logic [2:0]             code;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign issue       = cell_valid_i && out_free;
  assign last        = (idx_q == cell_i.last_idx);
  assign cell_done_o = issue && last;

  always_comb begin
    corner[0] = cell_i.first;
    corner[1] = cell_i.first + NODE_W'(1);
    corner[2] = cell_i.first + NODE_W'(geom_i.row) + NODE_W'(1);
    corner[3] = cell_i.first + NODE_W'(geom_i.row);
    for (int j = 0; j < 4; j++) begin
      corner[j+4] = corner[j] + NODE_W'(geom_i.layer);
    end
  end

  always_comb begin
    pos                = '0;
    code               = '0;
    elem_d.nodes       = '0;
    elem_d.shape       = cell_i.shape;
    elem_d.material    = geom_i.material;
    elem_d.bad         = cell_i.bad;
    elem_d.last        = last;
    if (cell_i.bad) begin
      elem_d.shape = SHAPE_TET;
    end else begin
      case (cell_i.shape)
        SHAPE_TET: begin
          for (int j = 0; j < 4; j++) begin
            code            = TET_CODES[idx_q][j];
            pos             = code[1:0] + {1'b0, cell_i.parity};
            elem_d.nodes[j] = corner[{code[2], pos}];
          end
        end
        SHAPE_PRISM: begin
          for (int j = 0; j < 6; j++) begin
            elem_d.nodes[j] = corner[PRISM_CORNERS[idx_q[0]][j]];
          end
        end
        default: begin
          for (int j = 0; j < 8; j++) begin
            elem_d.nodes[j] = corner[j];
          end
        end
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cell_done_o) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (out_free) begin
        out_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      elem_q <= elem_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign elem_o      = elem_q;

endmodule

// File: tb/sv/grid_cell_connectivity_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_connectivity_test
// Self-checking bench for the grid cell connectivity block. A directed table
// covers register defaults, grid extremes, every mesh kind and cells outside
// the grid. Randomized phases follow, each with a fresh grid setup. Every
// element that comes out is compared with a table entry or a local expansion.
// Both channels see random gaps, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module grid_cell_connectivity_test;
  import gcc_pkg::*;

  localparam logic [1:0] KIND_HEXA  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // corner code: [1:0] position on the bottom face, [2] top face
  localparam logic [0:4][0:3][2:0] TET_PICK = {
    3'd0, 3'd1, 3'd3, 3'd4,
    3'd5, 3'd4, 3'd6, 3'd1,
    3'd2, 3'd3, 3'd1, 3'd6,
    3'd7, 3'd6, 3'd4, 3'd3,
    3'd4, 3'd1, 3'd3, 3'd6
  };

  localparam logic [0:1][0:5][2:0] PRISM_PICK = {
    3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6,
    3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7
  };

  typedef struct packed {
    logic [0:7][23:0] node;
    logic [1:0]       shape;
    logic [15:0]      material;
    logic             bad;
    logic             last;
  } tb_elem_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_idx_e    reg_idx;
    logic [15:0] data;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic        known;
    tb_elem_t    want;
  } tb_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_CELLS_X;
  logic [15:0] cfg_data_i  = 16'h0000;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  cell_x_i    = 8'h00;
  logic [7:0]  cell_y_i    = 8'h00;
  logic [7:0]  cell_z_i    = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] node_a_o, node_b_o, node_c_o, node_d_o;
  logic [23:0] node_e_o, node_f_o, node_g_o, node_h_o;
  logic [1:0]  element_shape_o;
  logic [15:0] element_material_o;
  logic        cell_bad_o;
  logic        last_element_o;

  logic [7:0]  grid_x   = 8'd1;
  logic [7:0]  grid_y   = 8'd1;
  logic [7:0]  grid_z   = 8'd1;
  logic [1:0]  kind     = KIND_HEXA;
  logic [15:0] material = 16'h0000;

  tb_elem_t    pending_elems [$];
  tb_row_t     directed_rows [$];
  int unsigned cells_sent   = 0;
  int unsigned elems_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned tet_seen     = 0;
  int unsigned prism_seen   = 0;
  int unsigned hex_seen     = 0;
  int unsigned outside_seen = 0;
  logic        quiet        = 1'b0;
  logic        hold_off     = 1'b0;

  grid_cell_connectivity dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cell_x_i           (cell_x_i),
    .cell_y_i           (cell_y_i),
    .cell_z_i           (cell_z_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .node_a_o           (node_a_o),
    .node_b_o           (node_b_o),
    .node_c_o           (node_c_o),
    .node_d_o           (node_d_o),
    .node_e_o           (node_e_o),
    .node_f_o           (node_f_o),
    .node_g_o           (node_g_o),
    .node_h_o           (node_h_o),
    .element_shape_o    (element_shape_o),
    .element_material_o (element_material_o),
    .cell_bad_o         (cell_bad_o),
    .last_element_o     (last_element_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void expand_cell(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z);
    int unsigned      nx, ny, nz, row, layer, first;
    logic [0:7][23:0] corner;
    logic [2:0]       code;
    logic [1:0]       pos;
    logic             parity;
    tb_elem_t         e;
    nx = (grid_x > MAX_DIVISIONS) ? MAX_DIVISIONS : grid_x;
    ny = (grid_y > MAX_DIVISIONS) ? MAX_DIVISIONS : grid_y;
    nz = (grid_z > MAX_DIVISIONS) ? MAX_DIVISIONS : grid_z;
    e = '0;
    e.material = material;
    if (x >= nx || y >= ny || z >= nz) begin
      e.shape = SHAPE_TET;
      e.bad   = 1'b1;
      e.last  = 1'b1;
      pending_elems.push_back(e);
    end else begin
      row   = nx + 1;
      layer = row * (ny + 1);
      first = z * layer + y * row + x;
      corner[0] = 24'(first);
      corner[1] = 24'(first + 1);
      corner[2] = 24'(first + 1 + row);
      corner[3] = 24'(first + row);
      for (int j = 0; j < 4; j++) corner[j + 4] = 24'(corner[j] + layer);
      parity = x[0] ^ y[0] ^ z[0];
      if (kind == KIND_TET) begin
        for (int k = 0; k < 5; k++) begin
          e.node = '0;
          for (int j = 0; j < 4; j++) begin
            code = TET_PICK[k][j];
            pos  = code[1:0] + {1'b0, parity};
            e.node[j] = corner[{code[2], pos}];
          end
          e.shape = SHAPE_TET;
          e.last  = (k == 4);
          pending_elems.push_back(e);
        end
      end else if (kind == KIND_PRISM) begin
        for (int k = 0; k < 2; k++) begin
          e.node = '0;
          for (int j = 0; j < 6; j++) e.node[j] = corner[PRISM_PICK[k][j]];
          e.shape = SHAPE_PRISM;
          e.last  = (k == 1);
          pending_elems.push_back(e);
        end
      end else begin
        e.node  = corner;
        e.shape = SHAPE_HEX;
        e.last  = 1'b1;
        pending_elems.push_back(e);
      end
    end
  endfunction

  function automatic void check_elem(input tb_elem_t want, input tb_elem_t got);
    for (int i = 0; i < 8; i++) begin
      if (got.node[i] !== want.node[i]) begin
        mismatches++;
        $display("%0t: node_%c expected %0d got %0d", $time, 8'(97 + i),
                 want.node[i], got.node[i]);
      end
    end
    if (got.shape !== want.shape) begin
      mismatches++;
      $display("%0t: element_shape expected %0d got %0d", $time, want.shape, got.shape);
    end
    if (got.material !== want.material) begin
      mismatches++;
      $display("%0t: element_material expected %h got %h", $time, want.material,
               got.material);
    end
    if (got.bad !== want.bad) begin
      mismatches++;
      $display("%0t: cell_bad expected %b got %b", $time, want.bad, got.bad);
    end
    if (got.last !== want.last) begin
      mismatches++;
      $display("%0t: last_element expected %b got %b", $time, want.last, got.last);
    end
  endfunction

  function automatic int unsigned idle_draw();
    if (quiet) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 19);
  endfunction

  function automatic logic [7:0] pick_coord(input logic [7:0] n);
    if (n == 0 || $urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [15:0] draw_count();
    int unsigned sel;
    logic [7:0]  cnt;
    sel = $urandom_range(0, 29);
    if (sel == 0) cnt = 8'd0;
    else if (sel <= 5) cnt = 8'd1;
    else if (sel <= 10) cnt = 8'd255;
    else if (sel <= 15) cnt = 8'($urandom_range(2, 4));
    else cnt = 8'($urandom_range(1, 255));
    return {8'($urandom), cnt};
  endfunction

  function automatic tb_row_t cfg_row(input cfg_idx_e idx, input logic [15:0] data);
    tb_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.data    = data;
    return r;
  endfunction

  function automatic tb_row_t cell_row(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
    tb_row_t r;
    r = '0;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic tb_row_t known_row(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] z, input tb_elem_t want);
    tb_row_t r;
    r = cell_row(x, y, z);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic tb_elem_t outside_elem(input logic [15:0] mat);
    tb_elem_t e;
    e = '0;
    e.shape    = SHAPE_TET;
    e.material = mat;
    e.bad      = 1'b1;
    e.last     = 1'b1;
    return e;
  endfunction

  function automatic tb_elem_t hex_elem(input logic [0:7][23:0] n, input logic [15:0] mat);
    tb_elem_t e;
    e = '0;
    e.node     = n;
    e.shape    = SHAPE_HEX;
    e.material = mat;
    e.last     = 1'b1;
    return e;
  endfunction

  task automatic send_cell(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                           input logic known, input tb_elem_t want);
    int unsigned gap;
    gap = hold_off ? 0 : idle_draw();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_x_i   <= x;
    cell_y_i   <= y;
    cell_z_i   <= z;
    do @(posedge clk_i); while (in_stall_o);
    if (known) pending_elems.push_back(want);
    else expand_cell(x, y, z);
    cells_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CELLS_X:  grid_x = data[7:0];
      CFG_CELLS_Y:  grid_y = data[7:0];
      CFG_CELLS_Z:  grid_z = data[7:0];
      CFG_MESH:     kind = data[1:0];
      CFG_MATERIAL: material = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // output side: check each element, then hold stall for a random count
  initial begin : sink
    tb_elem_t    got;
    tb_elem_t    want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.node     = {node_a_o, node_b_o, node_c_o, node_d_o,
                        node_e_o, node_f_o, node_g_o, node_h_o};
        got.shape    = element_shape_o;
        got.material = element_material_o;
        got.bad      = cell_bad_o;
        got.last     = last_element_o;
        elems_seen++;
        if (pending_elems.size() == 0) begin
          mismatches++;
          $display("%0t: element with nothing expected, expected none got node_a %0d",
                   $time, got.node[0]);
        end else begin
          want = pending_elems.pop_front();
          check_elem(want, got);
          if (want.bad) outside_seen++;
          else if (want.shape == SHAPE_TET) tet_seen++;
          else if (want.shape == SHAPE_PRISM) prism_seen++;
          else hex_seen++;
        end
        stall_left = idle_draw();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= hold_off || (stall_left != 0);
    end
  end

  // long output hold-off in mid run so the block backs up to its input
  initial begin : backpressure
    wait (cells_sent >= 185);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("grid_cell_connectivity_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    tb_row_t r;
    logic    in_cfg;
    in_cfg = 1'b0;

    directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, hex_elem(
      {24'd0, 24'd1, 24'd3, 24'd2, 24'd4, 24'd5, 24'd7, 24'd6}, 16'h0000)));
    directed_rows.push_back(known_row(8'd1, 8'd0, 8'd0, outside_elem(16'h0000)));
    directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, outside_elem(16'h0000)));
    directed_rows.push_back(cfg_row(CFG_CELLS_X, 16'h00FF));
    directed_rows.push_back(cfg_row(CFG_CELLS_Y, 16'h00FF));
    directed_rows.push_back(cfg_row(CFG_CELLS_Z, 16'h00FF));
    directed_rows.push_back(cfg_row(CFG_MESH, {14'd0, KIND_HEXA}));
    directed_rows.push_back(cfg_row(CFG_MATERIAL, 16'hFFFF));
    directed_rows.push_back(known_row(8'd254, 8'd254, 8'd254, hex_elem(
      {24'd16711422, 24'd16711423, 24'd16711679, 24'd16711678,
       24'd16776958, 24'd16776959, 24'd16777215, 24'd16777214}, 16'hFFFF)));
    directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, hex_elem(
      {24'd0, 24'd1, 24'd257, 24'd256, 24'd65536, 24'd65537, 24'd65793, 24'd65792},
      16'hFFFF)));
    directed_rows.push_back(known_row(8'd255, 8'd0, 8'd0, outside_elem(16'hFFFF)));
    directed_rows.push_back(cfg_row(CFG_MESH, {14'd0, KIND_TET}));
    directed_rows.push_back(cell_row(8'd0, 8'd0, 8'd0));
    directed_rows.push_back(cell_row(8'd1, 8'd0, 8'd0));
    directed_rows.push_back(cell_row(8'd254, 8'd254, 8'd254));
    directed_rows.push_back(cell_row(8'd3, 8'd5, 8'd7));
    directed_rows.push_back(cell_row(8'd2, 8'd0, 8'd0));
    directed_rows.push_back(known_row(8'd0, 8'd0, 8'd255, outside_elem(16'hFFFF)));
    directed_rows.push_back(cfg_row(CFG_MESH, {14'd0, KIND_PRISM}));
    directed_rows.push_back(cell_row(8'd0, 8'd0, 8'd0));
    directed_rows.push_back(cell_row(8'd254, 8'd253, 8'd1));
    directed_rows.push_back(known_row(8'd7, 8'd255, 8'd0, outside_elem(16'hFFFF)));
    directed_rows.push_back(cfg_row(CFG_MESH, {14'd0, KIND_SPARE}));
    directed_rows.push_back(cfg_row(CFG_MATERIAL, 16'h5A5A));
    directed_rows.push_back(cell_row(8'd2, 8'd3, 8'd4));
    directed_rows.push_back(cell_row(8'd254, 8'd0, 8'd254));
    directed_rows.push_back(cfg_row(CFG_CELLS_X, 16'h0000));
    directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, outside_elem(16'h5A5A)));
    directed_rows.push_back(cfg_row(CFG_CELLS_X, 16'h0001));
    directed_rows.push_back(cfg_row(CFG_CELLS_Y, 16'hA502));
    directed_rows.push_back(cfg_row(CFG_CELLS_Z, 16'h0003));
    directed_rows.push_back(cfg_row(CFG_MESH, {14'd0, KIND_TET}));
    directed_rows.push_back(cfg_row(CFG_MATERIAL, 16'h8001));
    directed_rows.push_back(cell_row(8'd0, 8'd1, 8'd2));
    directed_rows.push_back(known_row(8'd0, 8'd2, 8'd0, outside_elem(16'h8001)));
    directed_rows.push_back(known_row(8'd1, 8'd0, 8'd0, outside_elem(16'h8001)));
    directed_rows.push_back(cell_row(8'd0, 8'd0, 8'd0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) begin
        if (!in_cfg) settle();
        write_reg(r.reg_idx, r.data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_valid_i <= 1'b0;
        send_cell(r.x, r.y, r.z, r.known, r.want);
        in_cfg = 1'b0;
      end
    end

    for (int p = 0; p < 12; p++) begin
      settle();
      quiet = (p % 3 == 2);
      write_reg(CFG_CELLS_X, draw_count());
      write_reg(CFG_CELLS_Y, draw_count());
      write_reg(CFG_CELLS_Z, draw_count());
      write_reg(CFG_MESH, {14'($urandom), 2'($urandom)});
      write_reg(CFG_MATERIAL, ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom));
      cfg_valid_i <= 1'b0;
      repeat (40) begin
        send_cell(pick_coord(grid_x), pick_coord(grid_y), pick_coord(grid_z), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d cells giving %0d elements: %0d tetrahedra, %0d prisms,",
             cells_sent, elems_seen, tet_seen, prism_seen);
    $display("  %0d hexahedra, %0d cells outside the grid; %0d field mismatches",
             hex_seen, outside_seen, mismatches);
    if (mismatches == 0) begin
      $display("grid_cell_connectivity_test: done, clean");
    end else begin
      $display("grid_cell_connectivity_test: done, errors");
    end
    $finish;
  end

endmodule

// File: grid_cell_connectivity.f
+incdir+design
design/gcc_pkg.sv
design/gcc_cfg.sv
design/gcc_corner.sv
design/gcc_emit.sv
design/grid_cell_connectivity.sv
tb/sv/grid_cell_connectivity_test.sv
